### rtl/lbmd_pkg.sv
// Shared constants, operation codes and the streaming offset table for the D2Q9 store.
package lbmd_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
  localparam int DIRS        = 9;

  localparam int CELL_W      = $clog2(CELLS);
  localparam int DIR_W       = $clog2(DIRS);
  localparam int CNT_W       = $clog2(DIRS + 1);
  localparam int ADDR_W      = $clog2(DIRS * CELLS);

  localparam int OP_W        = 2;
  localparam int DIR_REQ_W   = 4;
  localparam int CELL_REQ_W  = 12;
  localparam int VALUE_W     = 16;
  localparam int DENS_W      = 20;
  localparam int DENS_MAX    = DIRS * ((1 << VALUE_W) - 1);

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Per-step offset advance of plane idx: (dx + GRID_WIDTH*dy) reduced modulo the cell count.
  function automatic logic [CELL_W-1:0] plane_delta(input int idx);
    int dx;
    int dy;
    int ux;
    int uy;
    int xs;
    int ys;
    int s;
    dx = 0;
    dy = 0;
    case (idx)
      1: begin dx = 1;  dy = 0;  end
      2: begin dx = 1;  dy = 1;  end
      3: begin dx = 0;  dy = 1;  end
      4: begin dx = -1; dy = 1;  end
      5: begin dx = -1; dy = 0;  end
      6: begin dx = -1; dy = -1; end
      7: begin dx = 0;  dy = -1; end
      8: begin dx = 1;  dy = -1; end
      default: begin dx = 0; dy = 0; end
    endcase
    ux = 1 % CELLS;
    uy = GRID_WIDTH % CELLS;
    xs = (dx > 0) ? ux : ((dx < 0) ? ((CELLS - ux) % CELLS) : 0);
    ys = (dy > 0) ? uy : ((dy < 0) ? ((CELLS - uy) % CELLS) : 0);
    s  = (xs + ys) % CELLS;
    return CELL_W'(s);
  endfunction

endpackage

### rtl/lbm_d2q9_stream_density.sv
// D2Q9 distribution store with offset-based periodic streaming and cell density readout.
//
// Input channel (req_valid/req_ready) carries one word per command: operation,
// direction, cell_req and load_value. Output channel (rsp_valid/rsp_ready)
// carries the density of a read.
// A load writes one distribution value into the single-port store; a step
// advances all nine plane offsets at once. Neither leaves the idle state, so
// loads and steps can be accepted back to back and never produce a response
// word. A read fetches one distribution per plane from the store, one per
// cycle, and accumulates them: the read of plane k is issued while plane k-1
// returns. A read keeps the block busy while the nine store reads pass through
// one memory port; the next command can be taken once the density has been
// loaded into the output register.
// A read of a cell outside the grid returns a density of zero.
// rsp_valid and density hold until rsp_ready. A finished density waits in an
// output register, so commands keep flowing while the receiver stalls; only a
// second read completing against a stalled output waits for it to drain.
// Synchronous reset clears the plane offsets, the sequencer and rsp_valid.
// The store contents are undefined until loaded.
module lbm_d2q9_stream_density (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [lbmd_pkg::OP_W-1:0]       operation,
  input  logic [lbmd_pkg::DIR_REQ_W-1:0]  direction,
  input  logic [lbmd_pkg::CELL_REQ_W-1:0] cell_req,
  input  logic [lbmd_pkg::VALUE_W-1:0]    load_value,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [lbmd_pkg::DENS_W-1:0]     density
);
  import lbmd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CNT_W-1:0]    cnt;
  logic [CELL_W-1:0]   cur_cell;
  logic                cell_ok;
  logic [DENS_W-1:0]   acc;
  logic [DENS_W-1:0]   acc_next;
  logic [VALUE_W-1:0]  rdata;
  logic [CELL_W-1:0]   offs [DIRS];

  logic [VALUE_W-1:0]  store [DIRS*CELLS];

  logic                accept;
  logic                req_cell_ok;
  logic [CELL_W-1:0]   req_cell;
  logic                load_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [DIR_W-1:0]    rd_plane;
  logic [CELL_W-1:0]   off_rd;
  logic [CELL_W:0]     diff;
  logic [CELL_W-1:0]   src;
  logic [ADDR_W-1:0]   rd_addr;
  logic                finish;
  logic                out_free;
  logic                load_rsp;
  logic [DENS_W-1:0]   sum_final;
  logic [DENS_W-1:0]   rsp_data;

  assign req_ready   = (state == ST_IDLE);
  assign accept      = req_valid && req_ready;
  assign req_cell_ok = (32'(cell_req) < CELLS);
  assign req_cell    = req_cell_ok ? CELL_W'(cell_req) : '0;
  assign load_en     = accept && (operation == OP_LOAD) && req_cell_ok &&
                       (32'(direction) < DIRS);
  assign wr_addr     = ADDR_W'(direction) * ADDR_W'(CELLS) + ADDR_W'(req_cell);

  // Plane index of the store read issued this cycle.
  assign rd_en    = (state == ST_RUN) && (32'(cnt) < DIRS);
  assign rd_plane = rd_en ? cnt[DIR_W-1:0] : '0;
  assign off_rd   = offs[rd_plane];
  assign diff     = {1'b0, cur_cell} - {1'b0, off_rd};
  assign src      = diff[CELL_W] ? CELL_W'(diff + (CELL_W+1)'(CELLS)) : diff[CELL_W-1:0];
  assign rd_addr  = ADDR_W'(rd_plane) * ADDR_W'(CELLS) + ADDR_W'(src);

  // Data of plane cnt-1 is in rdata whenever cnt is nonzero.
  assign acc_next  = (cnt != '0) ? (acc + DENS_W'(rdata)) : acc;
  assign finish    = (state == ST_RUN) && (32'(cnt) == DIRS);
  assign sum_final = cell_ok ? acc_next : '0;
  assign out_free  = !rsp_valid || rsp_ready;
  assign load_rsp  = (finish || (state == ST_HOLD)) && out_free;
  assign rsp_data  = (state == ST_HOLD) ? acc : sum_final;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_READ)) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (finish) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      store[wr_addr] <= load_value;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_READ)) begin
      cur_cell <= req_cell;
      cell_ok  <= req_cell_ok;
      acc      <= '0;
    end else if (finish) begin
      acc <= sum_final;
    end else if (state == ST_RUN) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIRS; i++) begin
        offs[i] <= '0;
      end
    end else if (accept && (operation == OP_STEP)) begin
      for (int i = 0; i < DIRS; i++) begin
        logic [CELL_W:0] s;
        s = {1'b0, offs[i]} + {1'b0, plane_delta(i)};
        if (s >= (CELL_W+1)'(CELLS)) begin
          s = s - (CELL_W+1)'(CELLS);
        end
        offs[i] <= s[CELL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      density <= rsp_data;
    end
  end

endmodule

### rtl/lbmd_check.sv
// Port-level checks for the D2Q9 store, bound to the top level.
module lbmd_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic [lbmd_pkg::OP_W-1:0]       operation,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [lbmd_pkg::DENS_W-1:0]     density
);
  import lbmd_pkg::*;

  // A stalled response word holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(density))
    else $error("response word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A read keeps the block busy while it walks the nine planes.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (operation == OP_READ) |=> !req_ready ##1 !req_ready)
    else $error("command taken during a density read");

  // Loads and steps never produce a response word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (operation != OP_READ) && !rsp_valid |=> !rsp_valid)
    else $error("response without a read");

  a_dens_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(density) <= DENS_MAX))
    else $error("density above nine full-scale values");

endmodule

bind lbm_d2q9_stream_density lbmd_check u_lbmd_check (.*);
